// ===== hdl/spq_pkg.sv =====
// Package for the sorted priority queue: sizes, codes, entry layout and state type.
package spq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int ENTRY_W     = 32;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0]  prio;
      logic [15:0] rec;
      logic [7:0]  age;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_REM_HEAD,
      ST_REM_RD,
      ST_REM_MOVE,
      ST_RESP
   } state_type;

endpackage

// ===== hdl/spq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module spq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== hdl/sorted_priority_queue_core.sv =====
// Top level of the sorted priority queue: request sequencer, entry walk and result register.
//
// Usage. A request is a transfer on the input side: it is taken at a rising clock edge where
// start is high and busy is low. req_type selects insert (priority, record number, age) or
// remove of the front entry. The queue holds up to QUEUE_DEPTH entries in priority order,
// highest first; entries of equal priority leave in the order in which they arrived.
// Every request yields exactly one result transfer: rsp_valid is high for one cycle and the
// rsp_ ports carry the status, the removed entry (zero unless a remove succeeded) and the
// number of entries held after the request. The receiver cannot stall; a result that is not
// captured in its strobe cycle is gone.
//
// Timing. Entries live in a one-port-pair RAM, and all movement goes through it one entry at
// a time (read, then compare and write back). An insert walks from the back, moving each
// entry of lower priority one place toward the back, and writes the new entry where the walk
// stops or at the front; a full or empty rejection goes straight to the result; a remove
// takes the front entry and moves every later entry one place forward. busy stays high until
// the cycle after the strobe, when the next request can be taken. A remove from a full
// queue is the slowest request, set by the single read port of the entry RAM.
//
// Reset. A synchronous active-high reset empties the queue at once; the RAM is not cleared,
// since only entries below the held count are ever used.
module sorted_priority_queue_core
   import spq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_type,
   input  logic [7:0]  req_priority_req,
   input  logic [15:0] req_record_number,
   input  logic [7:0]  req_patient_age,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_out_record_number,
   output logic [7:0]  rsp_out_age,
   output logic [7:0]  rsp_out_priority,
   output logic [4:0]  rsp_entry_count
);

   // Control registers.
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;

   // Payload registers: the latched request and the pending result.
   entry_type  new_ff, new_in;
   status_type status_ff, status_in;
   entry_type  out_ff, out_in;

   // RAM connections.
   logic      ram_we;
   logic [IDX_W-1:0] ram_waddr, ram_raddr;
   entry_type ram_wdata;
   logic [ENTRY_W-1:0] ram_rdata_raw;
   entry_type ram_rdata;

   logic             accept;
   logic [CNT_W-1:0] idx_dec;
   logic             walk_stop;
   logic [CNT_W+4:0] count_ext;

   assign ram_rdata = entry_type'(ram_rdata_raw);
   assign accept    = start && (state_ff == ST_IDLE);
   assign idx_dec   = idx_ff - CNT_W'(1);

   // The shared compare unit: the new entry settles behind any entry of equal or higher
   // priority, which keeps equal priorities in arrival order.
   assign walk_stop = (ram_rdata.prio >= new_ff.prio);

   spq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata_raw)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_type == REQ_INSERT) begin
                  state_in = (count_ff == CNT_W'(QUEUE_DEPTH)) ? ST_RESP : ST_INS_RD;
               end else begin
                  state_in = (count_ff == '0) ? ST_RESP : ST_REM_HEAD;
               end
            end
         end
         ST_INS_RD: begin
            state_in = (idx_ff == '0) ? ST_RESP : ST_INS_CMP;
         end
         ST_INS_CMP: begin
            state_in = walk_stop ? ST_RESP : ST_INS_RD;
         end
         ST_REM_HEAD: begin
            state_in = ST_REM_RD;
         end
         ST_REM_RD: begin
            state_in = (idx_ff >= count_ff) ? ST_RESP : ST_REM_MOVE;
         end
         ST_REM_MOVE: begin
            state_in = ST_REM_RD;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs of the sequencer: RAM controls and datapath updates.
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = idx_ff[IDX_W-1:0];
      ram_wdata = new_ff;
      ram_raddr = '0;
      count_in  = count_ff;
      idx_in    = idx_ff;
      new_in    = new_ff;
      status_in = status_ff;
      out_in    = out_ff;
      case (state_ff)
         ST_IDLE: begin
            // The read port idles on the front entry so that a remove finds it ready.
            if (accept) begin
               new_in    = '{prio: req_priority_req, rec: req_record_number,
                             age: req_patient_age};
               out_in    = '0;
               status_in = STATUS_OK;
               if (req_type == REQ_INSERT) begin
                  idx_in = count_ff;
                  if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
                     status_in = STATUS_FULL;
                  end
               end else begin
                  idx_in = CNT_W'(1);
                  if (count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                  end
               end
            end
         end
         ST_INS_RD: begin
            if (idx_ff == '0) begin
               ram_we   = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end else begin
               ram_raddr = idx_dec[IDX_W-1:0];
            end
         end
         ST_INS_CMP: begin
            ram_we = 1'b1;
            if (walk_stop) begin
               count_in = count_ff + CNT_W'(1);
            end else begin
               ram_wdata = ram_rdata;
               idx_in    = idx_dec;
            end
         end
         ST_REM_HEAD: begin
            out_in = ram_rdata;
         end
         ST_REM_RD: begin
            if (idx_ff >= count_ff) begin
               count_in = count_ff - CNT_W'(1);
            end else begin
               ram_raddr = idx_ff[IDX_W-1:0];
            end
         end
         ST_REM_MOVE: begin
            ram_we    = 1'b1;
            ram_waddr = idx_dec[IDX_W-1:0];
            ram_wdata = ram_rdata;
            idx_in    = idx_ff + CNT_W'(1);
         end
         ST_RESP: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      new_ff    <= new_in;
      status_ff <= status_in;
      out_ff    <= out_in;
   end

   // The reported count is the held count taken to five bits.
   assign count_ext = {5'd0, count_ff};

   assign busy                  = (state_ff != ST_IDLE);
   assign rsp_valid             = (state_ff == ST_RESP);
   assign rsp_status            = status_ff;
   assign rsp_out_record_number = out_ff.rec;
   assign rsp_out_age           = out_ff.age;
   assign rsp_out_priority      = out_ff.prio;
   assign rsp_entry_count       = count_ext[4:0];

   // Every result ends the request: the block is free the cycle after the strobe.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !busy)
      else $error("block still busy after result strobe");

   // A taken request always starts work.
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("request accepted but block not busy");

   // The held count never exceeds the queue depth.
   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("held count beyond queue depth");

   // A full rejection is reported only when the queue is full, an empty one only when empty.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_FULL)) |-> (count_ff == CNT_W'(QUEUE_DEPTH)))
      else $error("full status with room in the queue");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_EMPTY)) |-> (count_ff == '0))
      else $error("empty status with entries held");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for sorted_priority_queue_core: directed and random request streams.
`timescale 1ns / 100ps

module tb;
   import spq_pkg::*;

   // The block takes one request per transfer and answers each with exactly one strobed
   // result. The testbench keeps its own ordered copy of the queue, works out the reply
   // for every accepted request and compares it with the strobed result.

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_type = REQ_INSERT;
   logic [7:0]  req_priority_req = '0;
   logic [15:0] req_record_number = '0;
   logic [7:0]  req_patient_age = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_out_record_number;
   logic [7:0]  rsp_out_age;
   logic [7:0]  rsp_out_priority;
   logic [4:0]  rsp_entry_count;

   sorted_priority_queue_core dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_type              (req_type),
      .req_priority_req      (req_priority_req),
      .req_record_number     (req_record_number),
      .req_patient_age       (req_patient_age),
      .rsp_valid             (rsp_valid),
      .rsp_status            (rsp_status),
      .rsp_out_record_number (rsp_out_record_number),
      .rsp_out_age           (rsp_out_age),
      .rsp_out_priority      (rsp_out_priority),
      .rsp_entry_count       (rsp_entry_count)
   );

   // One reply as the block should present it.
   typedef struct {
      status_type  status;
      logic [15:0] rec;
      logic [7:0]  age;
      logic [7:0]  prio;
      logic [4:0]  count;
   } queue_reply_type;

   // Ordered copy of the queue contents plus the replies still owed by the block.
   class priority_order_tracker_type;
      entry_type       slots [QUEUE_DEPTH];
      int              held;
      queue_reply_type awaited_replies [$];
      int              failures;

      function new();
         held     = 0;
         failures = 0;
      endfunction

      // Applies one accepted request to the copy and queues the reply it must cause.
      function void note_request(logic kind, logic [7:0] prio, logic [15:0] rec,
                                 logic [7:0] age);
         queue_reply_type r;
         int              pos;
         int              i;
         r.status = STATUS_OK;
         r.rec    = '0;
         r.age    = '0;
         r.prio   = '0;
         if (kind == REQ_INSERT) begin
            if (held >= QUEUE_DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               // New entry goes behind every entry of equal or higher priority.
               pos = 0;
               while (pos < held && slots[pos].prio >= prio) pos++;
               for (i = held; i > pos; i--) slots[i] = slots[i - 1];
               slots[pos].prio = prio;
               slots[pos].rec  = rec;
               slots[pos].age  = age;
               held++;
            end
         end else begin
            if (held == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               r.prio = slots[0].prio;
               r.rec  = slots[0].rec;
               r.age  = slots[0].age;
               for (i = 1; i < held; i++) slots[i - 1] = slots[i];
               held--;
            end
         end
         r.count = 5'(held);
         awaited_replies.push_back(r);
      endfunction

      // Compares one strobed result against the oldest reply owed.
      function void check_result(logic [1:0] status, logic [15:0] rec, logic [7:0] age,
                                 logic [7:0] prio, logic [4:0] count);
         queue_reply_type r;
         if (awaited_replies.size() == 0) begin
            $error("result strobed with no request outstanding");
            failures++;
            return;
         end
         r = awaited_replies.pop_front();
         if (status !== r.status) begin
            $error("status expected %0d actual %0d", r.status, status);
            failures++;
         end
         if (rec !== r.rec) begin
            $error("out_record_number expected %0h actual %0h", r.rec, rec);
            failures++;
         end
         if (age !== r.age) begin
            $error("out_age expected %0d actual %0d", r.age, age);
            failures++;
         end
         if (prio !== r.prio) begin
            $error("out_priority expected %0d actual %0d", r.prio, prio);
            failures++;
         end
         if (count !== r.count) begin
            $error("entry_count expected %0d actual %0d", r.count, count);
            failures++;
         end
      endfunction
   endclass

   priority_order_tracker_type tracker;

   initial begin
      forever #10 clock = ~clock;
   end

   // Both sides are observed at the rising edge, before any nonblocking update lands, so the
   // values seen are the ones the block itself sampled. A request transfer and a result
   // cannot share an edge, since busy stays high until after the strobe.
   always @(posedge clock) begin
      if (!reset && tracker != null) begin
         if (start && !busy)
            tracker.note_request(req_type, req_priority_req, req_record_number,
                                 req_patient_age);
         if (rsp_valid)
            tracker.check_result(rsp_status, rsp_out_record_number, rsp_out_age,
                                 rsp_out_priority, rsp_entry_count);
      end
   end

   // Presents one request and holds it until the block takes the transfer. start is left
   // high when the next request follows at once, and lowered only for an idle burst, so it
   // never gets two assignments in the same time step.
   task automatic issue_request(input logic kind, input logic [7:0] prio,
                                input logic [15:0] rec, input logic [7:0] age,
                                input int gap);
      req_type          <= kind;
      req_priority_req  <= prio;
      req_record_number <= rec;
      req_patient_age   <= age;
      start             <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Hard stop well beyond the slowest legal run.
   initial begin
      #10_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      int         n;
      int         blk;
      int         ins_pct;
      int         prio_mode;
      bit         idling;
      int         gap;
      int         waited;
      logic       kind;
      logic [7:0] prio;

      tracker = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Remove on an empty queue, field extremes, ties at the top, middle and
      // bottom of the priority range, two removes to show arrival order among equal priorities,
      // then fill to capacity so that one insert is refused, and a final remove.
      issue_request(REQ_REMOVE, 8'hFF, 16'hFFFF, 8'hFF, 0);
      issue_request(REQ_INSERT, 8'h00, 16'h0000, 8'h00, 0);
      issue_request(REQ_INSERT, 8'hFF, 16'hFFFF, 8'hFF, 0);
      issue_request(REQ_INSERT, 8'h80, 16'h1234, 8'h01, 0);
      issue_request(REQ_INSERT, 8'h80, 16'h5678, 8'h02, 0);
      issue_request(REQ_INSERT, 8'hFF, 16'h0001, 8'h03, 0);
      issue_request(REQ_INSERT, 8'h00, 16'hABCD, 8'h04, 0);
      issue_request(REQ_REMOVE, 8'h00, 16'h0000, 8'h00, 0);
      issue_request(REQ_REMOVE, 8'h55, 16'hAAAA, 8'h55, 0);
      for (n = 0; n < 12; n++)
         issue_request(REQ_INSERT, 8'((n % 4) * 85), 16'(16'h0100 + n), 8'(n), n % 3);
      issue_request(REQ_INSERT, 8'hFF, 16'hDEAD, 8'hBE, 0);
      issue_request(REQ_REMOVE, 8'h00, 16'h0000, 8'h00, 0);

      // Random part in blocks of 40 requests. Each block leans toward inserts, removes or
      // neither, so the queue swings between full and empty, and picks a priority spread:
      // a narrow band full of ties, the whole range, or only the two extremes. The last
      // 160 requests run back to back with no idle bursts.
      for (n = 0; n < 1200; n++) begin
         if (n % 40 == 0) begin
            blk = $urandom_range(2);
            ins_pct = (blk == 0) ? 20 : (blk == 1) ? 50 : 80;
            prio_mode = $urandom_range(2);
            idling = (n < 1040) && ($urandom_range(1) == 1);
         end
         kind = ($urandom_range(99) < ins_pct) ? REQ_INSERT : REQ_REMOVE;
         case (prio_mode)
            0: begin
               prio = 8'($urandom_range(3));
            end
            1: begin
               prio = 8'($urandom);
            end
            default: begin
               prio = ($urandom_range(1) == 1) ? 8'hFF : 8'h00;
            end
         endcase
         gap = (idling && $urandom_range(2) == 0) ? $urandom_range(1, 14) : 0;
         issue_request(kind, prio, 16'($urandom), 8'($urandom), gap);
      end
      start <= 1'b0;

      // Drain: wait for every owed reply, then give the block time to show any stray strobe.
      waited = 0;
      while (tracker.awaited_replies.size() != 0 && waited < 400) begin
         @(posedge clock);
         waited++;
      end
      repeat (40) @(posedge clock);
      if (tracker.awaited_replies.size() != 0) begin
         $error("%0d replies never strobed", tracker.awaited_replies.size());
         tracker.failures++;
      end

      if (tracker.failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== sorted_priority_queue_core.f =====
hdl/spq_pkg.sv
hdl/spq_ram.sv
hdl/sorted_priority_queue_core.sv
test/tb.sv
